// ===== rtl/sunesc_pkg.sv =====
// Shared types and constants of the string unescape and UTF-8 encode unit.
package sunesc_pkg;

  // Default depth of the descriptor queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Result kinds on the output channel
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] E_UNTERM  = 3'd0;
  localparam logic [2:0] E_NEWLINE = 3'd1;
  localparam logic [2:0] E_ILLEGAL = 3'd2;
  localparam logic [2:0] E_ESCAPE  = 3'd3;
  localparam logic [2:0] E_UNICODE = 3'd4;
  localparam logic [2:0] E_COMMENT = 3'd5;

  // Code point limits
  localparam logic [23:0] CP_MAX     = 24'h10FFFF;
  localparam logic [20:0] CP_MAX_1B  = 21'h00007F;
  localparam logic [20:0] CP_MAX_2B  = 21'h0007FF;
  localparam logic [20:0] CP_MAX_3B  = 21'h00FFFF;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_BODY    = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_CMT     = 3'd3,
    MODE_CMT_ESC = 3'd4
  } mode_t;

  // Kind of run held in one queue entry
  typedef enum logic [1:0] {
    DK_BYTE = 2'd0,
    DK_CP   = 2'd1,
    DK_END  = 2'd2,
    DK_ERR  = 2'd3
  } dkind_t;

  // One queued run: a single byte, a code point to encode, an end or an error
  typedef struct packed {
    dkind_t      dkind;
    logic [2:0]  code;
    logic [20:0] value;
  } desc_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/sunesc_if.sv =====
// Valid/ready channel interfaces for input bytes and result words.
interface sunesc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface sunesc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last_of_run, output ready);
endinterface

// ===== rtl/sunesc_front.sv =====
// Front part: accepts raw bytes, tracks the escape state and classifies each byte.
module sunesc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          data_byte,
  input  logic                end_of_data,
  output logic                in_ready,
  input  sunesc_pkg::qstat_t  qstat,
  output logic                push,
  output sunesc_pkg::desc_t   push_desc
);

  sunesc_pkg::mode_t mode, mode_next;
  logic [2:0]        digits, digits_next;
  logic              six, six_next;
  logic [23:0]       acc, acc_next;

  logic       fire;
  logic       is_ctrl;
  logic       is_sep;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [23:0] acc_shift;
  logic [2:0] digits_inc;
  logic [2:0] need;

  assign in_ready = !qstat.full;
  assign fire     = in_valid && in_ready;

  assign is_ctrl = (data_byte < 8'd32) || (data_byte == 8'd127);
  assign is_sep  = (data_byte == 8'h0A) || (data_byte == 8'h0D) || (data_byte == 8'h09);

  // Decode one hex digit
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte inside {[8'h30:8'h39]}) begin
      hex_val = data_byte[3:0];
    end else if (data_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      hex_val = data_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_shift  = {acc[19:0], hex_val};
  assign digits_inc = digits + 3'd1;
  assign need       = six ? 3'd6 : 3'd4;

  // Next state and the run to queue
  always_comb begin
    mode_next       = mode;
    digits_next     = digits;
    six_next        = six;
    acc_next        = acc;
    push            = 1'b0;
    push_desc.dkind = sunesc_pkg::DK_ERR;
    push_desc.code  = sunesc_pkg::E_UNTERM;
    push_desc.value = 21'd0;

    case (mode)
      sunesc_pkg::MODE_ESC: begin
        mode_next = sunesc_pkg::MODE_BODY;
        if (end_of_data) begin
          push           = 1'b1;
          push_desc.code = sunesc_pkg::E_ESCAPE;
        end else if (is_ctrl && !is_sep) begin
          push           = 1'b1;
          push_desc.code = sunesc_pkg::E_ILLEGAL;
        end else begin
          case (data_byte)
            8'h22, 8'h5C, 8'h2F: begin
              push            = 1'b1;
              push_desc.dkind = sunesc_pkg::DK_BYTE;
              push_desc.value = {13'd0, data_byte};
            end
            8'h6E, 8'h74, 8'h62, 8'h66, 8'h72: begin
              push            = 1'b1;
              push_desc.dkind = sunesc_pkg::DK_BYTE;
              case (data_byte)
                8'h6E:   push_desc.value = 21'h0A;
                8'h74:   push_desc.value = 21'h09;
                8'h62:   push_desc.value = 21'h08;
                8'h66:   push_desc.value = 21'h0C;
                default: push_desc.value = 21'h0D;
              endcase
            end
            8'h75, 8'h55: begin
              mode_next   = sunesc_pkg::MODE_HEX;
              digits_next = 3'd0;
              six_next    = (data_byte == 8'h55);
              acc_next    = 24'd0;
            end
            8'h5B: begin
              mode_next = sunesc_pkg::MODE_CMT;
            end
            default: begin
              push           = 1'b1;
              push_desc.code = sunesc_pkg::E_ESCAPE;
            end
          endcase
        end
      end

      sunesc_pkg::MODE_HEX: begin
        if (end_of_data || data_byte == 8'h0A || is_ctrl || !hex_ok) begin
          push = 1'b1;
          if (end_of_data)             push_desc.code = sunesc_pkg::E_UNICODE;
          else if (data_byte == 8'h0A) push_desc.code = sunesc_pkg::E_NEWLINE;
          else if (is_ctrl)            push_desc.code = sunesc_pkg::E_ILLEGAL;
          else                         push_desc.code = sunesc_pkg::E_UNICODE;
          mode_next   = sunesc_pkg::MODE_BODY;
          digits_next = 3'd0;
          six_next    = 1'b0;
          acc_next    = 24'd0;
        end else if (digits_inc < need) begin
          acc_next    = acc_shift;
          digits_next = digits_inc;
        end else begin
          // last digit: hand the code point to the back, or flag it out of range
          push        = 1'b1;
          mode_next   = sunesc_pkg::MODE_BODY;
          digits_next = 3'd0;
          six_next    = 1'b0;
          acc_next    = 24'd0;
          if (acc_shift > sunesc_pkg::CP_MAX) begin
            push_desc.code = sunesc_pkg::E_UNICODE;
          end else begin
            push_desc.dkind = sunesc_pkg::DK_CP;
            push_desc.value = acc_shift[20:0];
          end
        end
      end

      sunesc_pkg::MODE_CMT, sunesc_pkg::MODE_CMT_ESC: begin
        if (end_of_data || (is_ctrl && !is_sep)) begin
          push           = 1'b1;
          push_desc.code = end_of_data ? sunesc_pkg::E_COMMENT : sunesc_pkg::E_ILLEGAL;
          mode_next      = sunesc_pkg::MODE_BODY;
          digits_next    = 3'd0;
          six_next       = 1'b0;
          acc_next       = 24'd0;
        end else if (mode == sunesc_pkg::MODE_CMT_ESC && data_byte == 8'h5D) begin
          mode_next = sunesc_pkg::MODE_BODY;
        end else if (data_byte == 8'h5C) begin
          mode_next = sunesc_pkg::MODE_CMT_ESC;
        end else begin
          mode_next = sunesc_pkg::MODE_CMT;
        end
      end

      default: begin
        mode_next = sunesc_pkg::MODE_BODY;
        if (end_of_data || is_ctrl) begin
          push = 1'b1;
          if (end_of_data)             push_desc.code = sunesc_pkg::E_UNTERM;
          else if (data_byte == 8'h0A) push_desc.code = sunesc_pkg::E_NEWLINE;
          else                         push_desc.code = sunesc_pkg::E_ILLEGAL;
          digits_next = 3'd0;
          six_next    = 1'b0;
          acc_next    = 24'd0;
        end else if (data_byte == 8'h22) begin
          push            = 1'b1;
          push_desc.dkind = sunesc_pkg::DK_END;
          digits_next     = 3'd0;
          six_next        = 1'b0;
          acc_next        = 24'd0;
        end else if (data_byte == 8'h5C) begin
          mode_next = sunesc_pkg::MODE_ESC;
        end else begin
          push            = 1'b1;
          push_desc.dkind = sunesc_pkg::DK_BYTE;
          push_desc.value = {13'd0, data_byte};
        end
      end
    endcase

    // only an accepted byte moves the decoder or queues a run
    if (!fire) begin
      push        = 1'b0;
      mode_next   = mode;
      digits_next = digits;
      six_next    = six;
      acc_next    = acc;
    end
  end

  // Hold decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= sunesc_pkg::MODE_BODY;
      digits <= 3'd0;
      six    <= 1'b0;
      acc    <= 24'd0;
    end else begin
      mode   <= mode_next;
      digits <= digits_next;
      six    <= six_next;
      acc    <= acc_next;
    end
  end

endmodule

// ===== rtl/sunesc_queue.sv =====
// Short descriptor queue between the front and the back.
module sunesc_queue #(
  parameter int DEPTH = sunesc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sunesc_pkg::desc_t  push_desc,
  input  logic               pop,
  output sunesc_pkg::desc_t  head,
  output sunesc_pkg::qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sunesc_pkg::desc_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  // Store pushed runs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/sunesc_back.sv =====
// Back part: expands the queued run at the head into result words.
module sunesc_back (
  input  logic               clk,
  input  logic               rst,
  input  sunesc_pkg::desc_t  head,
  input  sunesc_pkg::qstat_t qstat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         kind,
  output logic [2:0]         error_code,
  output logic               last_of_run
);

  logic [1:0]  idx;
  logic [1:0]  last_idx;
  logic [20:0] cp;
  logic        fire;

  assign cp        = head.value;
  assign out_valid = !qstat.empty;
  assign fire      = out_valid && out_ready;
  assign last_of_run = (idx == last_idx);
  assign pop       = fire && last_of_run;

  // Length of the run, as index of its last word
  always_comb begin
    last_idx = 2'd0;
    if (head.dkind == sunesc_pkg::DK_CP) begin
      if (cp <= sunesc_pkg::CP_MAX_1B)      last_idx = 2'd0;
      else if (cp <= sunesc_pkg::CP_MAX_2B) last_idx = 2'd1;
      else if (cp <= sunesc_pkg::CP_MAX_3B) last_idx = 2'd2;
      else                                  last_idx = 2'd3;
    end
  end

  // Select the current word of the run
  always_comb begin
    out_byte   = 8'd0;
    kind       = sunesc_pkg::KIND_BYTE;
    error_code = 3'd0;
    case (head.dkind)
      sunesc_pkg::DK_BYTE: out_byte = cp[7:0];
      sunesc_pkg::DK_END:  kind = sunesc_pkg::KIND_END;
      sunesc_pkg::DK_ERR: begin
        kind       = sunesc_pkg::KIND_ERR;
        error_code = head.code;
      end
      default: begin
        case (last_idx)
          2'd0: out_byte = cp[7:0];
          2'd1: out_byte = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
          2'd2: begin
            case (idx)
              2'd0:    out_byte = {4'b1110, cp[15:12]};
              2'd1:    out_byte = {2'b10, cp[11:6]};
              default: out_byte = {2'b10, cp[5:0]};
            endcase
          end
          default: begin
            case (idx)
              2'd0:    out_byte = {5'b11110, cp[20:18]};
              2'd1:    out_byte = {2'b10, cp[17:12]};
              2'd2:    out_byte = {2'b10, cp[11:6]};
              default: out_byte = {2'b10, cp[5:0]};
            endcase
          end
        endcase
      end
    endcase
  end

  // Advance the word index, rewind after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= last_of_run ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== rtl/string_unescape_utf8_unit.sv =====
// The run of an accepted byte is written into the descriptor queue; its result words leave from the queue head.
// One input byte per cycle while the queue is not full; a code point of n UTF-8 bytes takes n output words.
// The front stalls only when the descriptor queue (QUEUE_DEPTH runs) is full.
// Bytes that give no result (backslash, leading hex digits, comment text) only move the decoder state.
// Reset (rst, synchronous) empties the queue and returns the decoder to the string body.
// Top level: string unescape and UTF-8 encode unit.
module string_unescape_utf8_unit #(
  parameter int QUEUE_DEPTH = sunesc_pkg::QUEUE_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst,
  sunesc_in_if.sink   in_ch,
  sunesc_out_if.source out_ch
);

  sunesc_pkg::qstat_t qstat;
  sunesc_pkg::desc_t  push_desc;
  sunesc_pkg::desc_t  head;
  logic               push;
  logic               pop;

  sunesc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .data_byte   (in_ch.data_byte),
    .end_of_data (in_ch.end_of_data),
    .in_ready    (in_ch.ready),
    .qstat       (qstat),
    .push        (push),
    .push_desc   (push_desc)
  );

  sunesc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  sunesc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .kind        (out_ch.kind),
    .error_code  (out_ch.error_code),
    .last_of_run (out_ch.last_of_run)
  );

endmodule

// ===== rtl/sunesc_checker.sv =====
// Port-level checks of the unescape unit, bound to the top level.
module sunesc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic [2:0] error_code,
  input logic       last_of_run
);

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(error_code) && $stable(last_of_run))
    else $error("output word changed while stalled");

  // End and error words are single, zero-byte runs
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sunesc_pkg::KIND_BYTE |-> last_of_run && out_byte == 8'd0)
    else $error("status word not a single zero-byte run");

  // Error code only on error words
  a_code_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sunesc_pkg::KIND_ERR |-> error_code == 3'd0)
    else $error("error code set on non-error word");

  // A multi-byte run continues with a byte word in the next cycle
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid && kind == sunesc_pkg::KIND_BYTE
      && out_byte[7:6] == 2'b10)
    else $error("multi-byte run broken");

endmodule

bind string_unescape_utf8_unit sunesc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .kind        (out_ch.kind),
  .error_code  (out_ch.error_code),
  .last_of_run (out_ch.last_of_run)
);
